// File: src/rgb_pixel_point_filter_core_defines.svh
`ifndef RGB_PIXEL_POINT_FILTER_CORE_DEFINES_SVH
`define RGB_PIXEL_POINT_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define RPPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define RPPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rppf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rppf_pkg;

  // Input pixel request
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_in_t;

  // Output pixel request
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pixel_out_t;

  // Filter mode codes
  localparam logic [2:0] MODE_GRAY     = 3'd0;
  localparam logic [2:0] MODE_SEPIA    = 3'd1;
  localparam logic [2:0] MODE_BRIGHT   = 3'd2;
  localparam logic [2:0] MODE_CONTRAST = 3'd3;
  localparam logic [2:0] MODE_INVERT   = 3'd4;
  localparam logic [2:0] MODE_PASS     = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_FILTER_MODE       = 2'd0;
  localparam logic [1:0] CFG_BRIGHTNESS_OFFSET = 2'd1;
  localparam logic [1:0] CFG_CONTRAST_GAIN     = 2'd2;

  // Reset values
  localparam logic [2:0] FILTER_MODE_RST       = MODE_GRAY;
  localparam logic [8:0] BRIGHTNESS_OFFSET_RST = 9'd50;
  localparam logic [7:0] CONTRAST_GAIN_RST     = 8'd24;

  // Luma weights, Q0.10
  localparam logic [9:0] LUMA_W [3] = '{10'd306, 10'd601, 10'd117};

  // Sepia matrix, Q0.10, one row per output channel
  localparam logic [9:0] SEPIA_W [3][3] = '{
    '{10'd402, 10'd787, 10'd194},
    '{10'd357, 10'd702, 10'd172},
    '{10'd279, 10'd547, 10'd134}
  };

  // Contrast midpoint bias: 128 scaled by 16 to match the Q4.4 gain's fraction bits
  localparam logic signed [16:0] CONTRAST_BIAS = 17'sd2048;
  localparam logic [8:0]         CONTRAST_MID  = 9'd128;

endpackage

`default_nettype wire

// File: src/rgb_pixel_point_filter_core.sv
// Throughput: one pixel per clock unless out_stall stalls the pipeline; an
// accepted pixel passes three pipeline registers (products, sums,
// saturate/select) to out_data; each holds one pixel and advances on a per-stage ready chain.
// Reset: synchronous active-high rst empties the pipeline and loads
// filter_mode 0, brightness_offset 50 and contrast_gain 24.
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_pixel_point_filter_core_defines.svh"

module rgb_pixel_point_filter_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire rppf_pkg::pixel_in_t   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output rppf_pkg::pixel_out_t       out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [8:0]            cfg_data
);
  import rppf_pkg::*;

  // Configuration registers
  logic [2:0] filter_mode;
  logic [8:0] brightness_offset;
  logic [7:0] contrast_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode       <= FILTER_MODE_RST;
      brightness_offset <= BRIGHTNESS_OFFSET_RST;
      contrast_gain     <= CONTRAST_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FILTER_MODE:       filter_mode       <= cfg_data[2:0];
        CFG_BRIGHTNESS_OFFSET: brightness_offset <= cfg_data;
        CFG_CONTRAST_GAIN:     contrast_gain     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Stage ready chain: a stage loads when it is empty or drains this cycle
  logic s1_valid;
  logic s2_valid;
  logic rdy1;
  logic rdy2;
  logic rdy3;

  assign rdy3     = !out_valid || !out_stall;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign in_stall = !rdy1;

  // Stage 1: constant-weight products, contrast product, brightness sum
  logic [7:0]         px [3];
  logic [17:0]        luma_prod [3];
  logic [17:0]        sep_prod [3][3];
  logic signed [16:0] con_prod [3];
  logic signed [9:0]  bri_sum [3];
  logic [7:0]         s1_px [3];
  logic [17:0]        s1_luma [3];
  logic [17:0]        s1_sep [3][3];
  logic signed [16:0] s1_con [3];
  logic signed [9:0]  s1_bri [3];
  logic signed [9:0]  off_ext;
  logic signed [8:0]  diff;

  assign px[0]   = in_data.red_in;
  assign px[1]   = in_data.green_in;
  assign px[2]   = in_data.blue_in;
  assign off_ext = $signed({brightness_offset[8], brightness_offset});

  always_comb begin
    diff = '0;
    for (int i = 0; i < 3; i++) begin
      luma_prod[i] = 18'(LUMA_W[i]) * 18'(px[i]);
      for (int j = 0; j < 3; j++) begin
        sep_prod[i][j] = 18'(SEPIA_W[i][j]) * 18'(px[j]);
      end
      diff        = $signed({1'b0, px[i]} - CONTRAST_MID);
      con_prod[i] = 17'(diff) * $signed({9'b0, contrast_gain});
      bri_sum[i]  = $signed({2'b00, px[i]}) + off_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      s1_px   <= px;
      s1_luma <= luma_prod;
      s1_sep  <= sep_prod;
      s1_con  <= con_prod;
      s1_bri  <= bri_sum;
    end
  end

  // Stage 2: weighted sums and contrast bias
  logic [7:0]         s2_px [3];
  logic [17:0]        s2_luma;
  logic [18:0]        s2_sep [3];
  logic signed [16:0] s2_con [3];
  logic signed [9:0]  s2_bri [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (rdy2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && rdy2) begin
      s2_px   <= s1_px;
      s2_luma <= s1_luma[0] + s1_luma[1] + s1_luma[2];
      for (int i = 0; i < 3; i++) begin
        s2_sep[i] <= 19'(s1_sep[i][0]) + 19'(s1_sep[i][1]) + 19'(s1_sep[i][2]);
        s2_con[i] <= s1_con[i] + CONTRAST_BIAS;
      end
      s2_bri <= s1_bri;
    end
  end

  // Stage 3: saturate and select by mode
  logic [7:0] res [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (filter_mode)
        MODE_GRAY: res[i] = s2_luma[17:10];
        MODE_SEPIA: res[i] = s2_sep[i][18] ? 8'hFF : s2_sep[i][17:10];
        MODE_BRIGHT: begin
          if (s2_bri[i][9])      res[i] = 8'h00;
          else if (s2_bri[i][8]) res[i] = 8'hFF;
          else                   res[i] = s2_bri[i][7:0];
        end
        MODE_CONTRAST: begin
          if (s2_con[i][16])                res[i] = 8'h00;
          else if (s2_con[i][15:12] != '0)  res[i] = 8'hFF;
          else                              res[i] = s2_con[i][11:4];
        end
        MODE_INVERT: res[i] = ~s2_px[i];
        MODE_PASS:   res[i] = s2_px[i];
        default:     res[i] = s2_px[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy3) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && rdy3) begin
      out_data.red_out   <= res[0];
      out_data.green_out <= res[1];
      out_data.blue_out  <= res[2];
    end
  end

  // Checks on the pipeline control
  `RPPF_ASSERT_NOW(a_empty_s1_takes, !s1_valid, !in_stall, "input stalled with stage 1 empty")
  `RPPF_ASSERT_NEXT(a_s2_moves_out, s2_valid && rdy3, out_valid, "stage 2 pixel lost")
  `RPPF_ASSERT_NEXT(a_drain_out, out_valid && !out_stall && !s2_valid, !out_valid,
                    "output repeated after drain")

endmodule

`default_nettype wire
